// ===== rtl/msp_pkg.sv =====
// Package for the MSP v1 frame receiver: word types, header bytes,
// parser phases and event codes. Depends on nothing.
`default_nettype none
package msp_pkg;

  localparam logic [7:0]  HDR_START        = 8'h24;
  localparam logic [7:0]  HDR_M            = 8'h4D;
  localparam logic [7:0]  HDR_DIR          = 8'h3E;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd500;
  localparam logic [15:0] IDLE_COUNT_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_GOT_S = 3'd1,
    PH_GOT_M = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_BODY  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_IDLE = 1'b1
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_byte;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/msp_frame_receiver.sv =====
// Receive side of the MSP v1 serial protocol. Input words are either a
// received byte or one idle tick; the block finds the '$','M','>' header,
// takes length and command, passes each payload byte on as a result word,
// then reports the checksum as good or bad, or a timeout after too many
// idle ticks inside a frame.
// Input channel: in_valid/in_ready with func and rx_byte. Output channel:
// out_valid/out_ready with event_res, data_byte, command, payload_length
// and last. Register idle_limit is written through cfg_wr_en/cfg_wr_data.
// An accepted word waits in the input register until the parser takes it,
// which it does while the output register is empty or being drained; the
// result, if any, is loaded into the output register as the word is taken
// and out_valid rises; one word per cycle is taken while this holds.
// Reset clears the phase, counters and both valid flags and sets idle_limit
// to 500. While the receiver stalls, the held result stays put, the parser
// waits on the word in its input register and in_ready falls once that
// register is full. Depends on msp_pkg, msp_in_reg, msp_parser, msp_out_reg.
`default_nettype none
module msp_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_res,
  output logic [7:0]       data_byte,
  output logic [7:0]       command,
  output logic [7:0]       payload_length,
  output logic             last
);

  logic [15:0]      idle_limit;
  msp_pkg::item_t   in_item;
  msp_pkg::item_t   q_item;
  logic             q_valid;
  logic             fire;
  logic             res_valid;
  msp_pkg::result_t res;
  msp_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= msp_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      idle_limit <= cfg_wr_data;
    end
  end

  assign in_item.func    = msp_pkg::func_t'(func);
  assign in_item.rx_byte = rx_byte;
  assign fire            = q_valid && (!out_valid || out_ready);

  msp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (fire),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  msp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (q_item),
    .idle_limit (idle_limit),
    .res_valid  (res_valid),
    .res        (res)
  );

  msp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .d         (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (res_q)
  );

  assign event_res      = res_q.event_res;
  assign data_byte      = res_q.data_byte;
  assign command        = res_q.command;
  assign payload_length = res_q.payload_length;
  assign last           = res_q.last;

endmodule
`default_nettype wire

// ===== rtl/msp_in_reg.sv =====
// Input register of the MSP frame receiver: holds one accepted word until
// the parser takes it. Depends on msp_pkg.
`default_nettype none
module msp_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire msp_pkg::item_t in_item,
  input  wire logic           take,
  output logic                q_valid,
  output msp_pkg::item_t      q_item
);

  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/msp_parser.sv =====
// Frame parser of the MSP frame receiver: phase machine, length, command,
// checksum and idle counters, producing at most one result per word.
// Depends on msp_pkg.
`default_nettype none
module msp_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire msp_pkg::item_t item,
  input  wire logic [15:0]    idle_limit,
  output logic                res_valid,
  output msp_pkg::result_t    res
);

  msp_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_taken, bytes_taken_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] idle_count, idle_count_next;
  logic [15:0] idle_inc;
  logic        timeout;
  logic        is_idle;
  logic        more_payload;
  logic [7:0]  c;

  assign c            = item.rx_byte;
  assign is_idle      = (item.func == msp_pkg::FUNC_IDLE);
  assign idle_inc     = (idle_count == msp_pkg::IDLE_COUNT_MAX) ? idle_count
                                                                : idle_count + 16'd1;
  assign timeout      = (phase != msp_pkg::PH_HUNT) && (idle_inc > idle_limit);
  assign more_payload = (bytes_taken < frame_length);

  always_comb begin
    phase_next = phase;
    if (fire) begin
      if (is_idle) begin
        if (timeout) begin
          phase_next = msp_pkg::PH_HUNT;
        end
      end else begin
        case (phase)
          msp_pkg::PH_HUNT: begin
            phase_next = (c == msp_pkg::HDR_START) ? msp_pkg::PH_GOT_S : msp_pkg::PH_HUNT;
          end
          msp_pkg::PH_GOT_S: begin
            phase_next = (c == msp_pkg::HDR_M) ? msp_pkg::PH_GOT_M : msp_pkg::PH_HUNT;
          end
          msp_pkg::PH_GOT_M: begin
            phase_next = (c == msp_pkg::HDR_DIR) ? msp_pkg::PH_LEN : msp_pkg::PH_HUNT;
          end
          msp_pkg::PH_LEN: begin
            phase_next = msp_pkg::PH_CMD;
          end
          msp_pkg::PH_CMD: begin
            phase_next = msp_pkg::PH_BODY;
          end
          msp_pkg::PH_BODY: begin
            phase_next = more_payload ? msp_pkg::PH_BODY : msp_pkg::PH_HUNT;
          end
          default: begin
            phase_next = msp_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    frame_length_next  = frame_length;
    bytes_taken_next   = bytes_taken;
    frame_command_next = frame_command;
    running_xor_next   = running_xor;
    idle_count_next    = idle_count;
    res_valid          = 1'b0;
    res.event_res      = msp_pkg::EV_PAYLOAD;
    res.data_byte      = 8'd0;
    res.command        = frame_command;
    res.payload_length = frame_length;
    res.last           = 1'b0;
    if (fire) begin
      if (is_idle) begin
        if (phase != msp_pkg::PH_HUNT) begin
          if (timeout) begin
            idle_count_next = 16'd0;
            res_valid       = 1'b1;
            res.event_res   = msp_pkg::EV_TIMEOUT;
            res.last        = 1'b1;
          end else begin
            idle_count_next = idle_inc;
          end
        end
      end else begin
        idle_count_next = 16'd0;
        case (phase)
          msp_pkg::PH_HUNT: begin
            if (c == msp_pkg::HDR_START) begin
              frame_length_next  = 8'd0;
              bytes_taken_next   = 8'd0;
              frame_command_next = 8'd0;
              running_xor_next   = 8'd0;
            end
          end
          msp_pkg::PH_LEN: begin
            frame_length_next = c;
            running_xor_next  = running_xor ^ c;
          end
          msp_pkg::PH_CMD: begin
            frame_command_next = c;
            running_xor_next   = running_xor ^ c;
          end
          msp_pkg::PH_BODY: begin
            res_valid = 1'b1;
            if (more_payload) begin
              running_xor_next = running_xor ^ c;
              bytes_taken_next = bytes_taken + 8'd1;
              res.data_byte    = c;
            end else begin
              res.event_res = (running_xor == c) ? msp_pkg::EV_GOOD : msp_pkg::EV_BAD;
              res.last      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= msp_pkg::PH_HUNT;
      frame_length  <= 8'd0;
      bytes_taken   <= 8'd0;
      frame_command <= 8'd0;
      running_xor   <= 8'd0;
      idle_count    <= 16'd0;
    end else begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      bytes_taken   <= bytes_taken_next;
      frame_command <= frame_command_next;
      running_xor   <= running_xor_next;
      idle_count    <= idle_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/msp_out_reg.sv =====
// Result register of the MSP frame receiver: holds one result word until
// the receiver takes it. Depends on msp_pkg.
`default_nettype none
module msp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire msp_pkg::result_t d,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output msp_pkg::result_t      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// ===== tb/msp_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the MSP v1 frame receiver: follows accepted input words and
// register writes, predicts every result word and compares it with the output.
// Depends on msp_pkg.
module msp_frame_checker
  import msp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  event_res,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  command,
  input  wire logic [7:0]  payload_length,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);

  phase_t      parse_phase;
  logic [7:0]  hdr_len;
  logic [7:0]  body_count;
  logic [7:0]  hdr_cmd;
  logic [7:0]  xor_acc;
  logic [15:0] gap_count;
  logic [15:0] gap_limit;
  result_t     expected_words[$];
  int          mismatches = 0;
  int          outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  always @(posedge clk) begin : track
    result_t want;
    result_t made;
    logic    emit_word;
    if (rst) begin
      parse_phase = PH_HUNT;
      hdr_len     = 8'h00;
      body_count  = 8'h00;
      hdr_cmd     = 8'h00;
      xor_acc     = 8'h00;
      gap_count   = 16'h0000;
      gap_limit   = IDLE_LIMIT_RESET;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: event_res %0d, data_byte %0h",
                 event_res, data_byte);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, event_res);
            mismatches++;
          end
          if (data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
            mismatches++;
          end
          if (command !== want.command) begin
            $error("command: expected %0h, got %0h", want.command, command);
            mismatches++;
          end
          if (payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d", want.payload_length,
                   payload_length);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        gap_limit = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        emit_word      = 1'b0;
        made.event_res = EV_PAYLOAD;
        made.data_byte = 8'h00;
        made.last      = 1'b1;
        if (func == FUNC_IDLE) begin
          if (parse_phase != PH_HUNT) begin
            if (gap_count != IDLE_COUNT_MAX) begin
              gap_count = gap_count + 16'd1;
            end
            if (gap_count > gap_limit) begin
              emit_word      = 1'b1;
              made.event_res = EV_TIMEOUT;
              parse_phase    = PH_HUNT;
              gap_count      = 16'h0000;
            end
          end
        end else begin
          gap_count = 16'h0000;
          case (parse_phase)
            PH_GOT_S: begin
              parse_phase = (rx_byte == HDR_M) ? PH_GOT_M : PH_HUNT;
            end
            PH_GOT_M: begin
              parse_phase = (rx_byte == HDR_DIR) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
              hdr_len     = rx_byte;
              xor_acc     = xor_acc ^ rx_byte;
              parse_phase = PH_CMD;
            end
            PH_CMD: begin
              hdr_cmd     = rx_byte;
              xor_acc     = xor_acc ^ rx_byte;
              parse_phase = PH_BODY;
            end
            PH_BODY: begin
              emit_word = 1'b1;
              if (body_count < hdr_len) begin
                xor_acc        = xor_acc ^ rx_byte;
                body_count     = body_count + 8'd1;
                made.event_res = EV_PAYLOAD;
                made.data_byte = rx_byte;
                made.last      = 1'b0;
              end else begin
                made.event_res = (xor_acc == rx_byte) ? EV_GOOD : EV_BAD;
                parse_phase    = PH_HUNT;
              end
            end
            default: begin
              if (rx_byte == HDR_START) begin
                parse_phase = PH_GOT_S;
                hdr_len     = 8'h00;
                body_count  = 8'h00;
                hdr_cmd     = 8'h00;
                xor_acc     = 8'h00;
              end else begin
                parse_phase = PH_HUNT;
              end
            end
          endcase
        end
        if (emit_word) begin
          made.command        = hdr_cmd;
          made.payload_length = hdr_len;
          expected_words.push_back(made);
        end
      end
    end
    outstanding = expected_words.size();
  end

endmodule

// ===== tb/tb_msp_frame_receiver.sv =====
`timescale 1ns / 100ps
// Top of the MSP v1 frame receiver testbench: drives directed and random
// frames, noise and idle ticks under several idle limits and stall patterns.
// Depends on msp_pkg, msp_frame_receiver and msp_frame_checker.
module tb_msp_frame_receiver;
  import msp_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  command;
  logic [7:0]  payload_length;
  logic        last;
  int          fail_count;
  int          pending;

  int          in_gap_pct = 18;
  int          out_stall_pct = 51;
  int          cur_limit = 500;
  int          words_sent = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  msp_frame_receiver u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .data_byte      (data_byte),
    .command        (command),
    .payload_length (payload_length),
    .last           (last)
  );

  msp_frame_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .data_byte      (data_byte),
    .command        (command),
    .payload_length (payload_length),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input func_t f, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idle_limit(input logic [15:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_limit    = int'(value);
  endtask

  task automatic send_random_frame();
    logic [7:0] frame_q[$];
    logic [7:0] len;
    logic [7:0] sum;
    int         sel;
    int         run;
    sel = $urandom_range(99);
    len = (sel < 85) ? 8'($urandom_range(0, 6)) :
          (sel < 97) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(41, 255));
    frame_q = '{HDR_START, HDR_M, HDR_DIR, len, 8'($urandom_range(255))};
    for (int n = 0; n < len; n++) frame_q.push_back(8'($urandom_range(255)));
    sum = 8'h00;
    for (int n = 3; n < frame_q.size(); n++) sum = sum ^ frame_q[n];
    if ($urandom_range(9) == 0) begin
      sum = sum ^ 8'(1 << $urandom_range(7));
    end
    frame_q.push_back(sum);
    if ($urandom_range(19) == 0) begin
      frame_q[$urandom_range(1, 2)] = 8'($urandom_range(255));
    end
    for (int n = 0; n < frame_q.size(); n++) begin
      if (n > 0) begin
        sel = $urandom_range(99);
        run = (sel < 15) ? $urandom_range(1, 3) :
              (sel < 17 && cur_limit <= 600) ? cur_limit + 1 : 0;
        repeat (run) send_word(FUNC_IDLE, 8'($urandom_range(255)));
      end
      send_word(FUNC_BYTE, frame_q[n]);
    end
  endtask

  initial begin
    int budget_end;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'h0000;
    in_valid    = 1'b0;
    func        = FUNC_BYTE;
    rx_byte     = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(FUNC_IDLE, 8'hFF);
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_BYTE, HDR_M);
    send_word(FUNC_BYTE, HDR_DIR);
    send_word(FUNC_BYTE, 8'h02);
    send_word(FUNC_BYTE, 8'hFF);
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'hFF);
    send_word(FUNC_BYTE, 8'h02);
    // A zero-length frame whose checksum is wrong.
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_BYTE, HDR_M);
    send_word(FUNC_BYTE, HDR_DIR);
    send_word(FUNC_BYTE, 8'h00);
    send_word(FUNC_BYTE, 8'h80);
    send_word(FUNC_BYTE, 8'h7F);
    // Header mismatches: the repeated start word is not taken as a new start.
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_BYTE, HDR_M);
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_BYTE, HDR_M);
    send_word(FUNC_BYTE, HDR_M);
    set_idle_limit(16'd1);
    send_word(FUNC_BYTE, HDR_START);
    send_word(FUNC_IDLE, 8'h00);
    send_word(FUNC_IDLE, 8'h00);

    for (int mode = 0; mode < 3; mode++) begin
      in_gap_pct    = (mode == 0) ? 18 : (mode == 1) ? 51 : 0;
      out_stall_pct = (mode == 0) ? 51 : (mode == 1) ? 18 : 0;
      for (int k = 0; k < 4; k++) begin
        set_idle_limit((k == 0) ? 16'd1 :
                       (k == 1) ? 16'($urandom_range(2, 20)) :
                       (k == 2) ? IDLE_LIMIT_RESET : 16'hFFFF);
        budget_end = words_sent + 167;
        while (words_sent < budget_end) begin
          if ($urandom_range(99) < 80) begin
            send_random_frame();
          end else begin
            repeat ($urandom_range(1, 6)) begin
              send_word(func_t'($urandom_range(1)), 8'($urandom_range(255)));
            end
          end
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
